// ===== design/aosc_pkg.sv =====
// ============================================================================
// aosc_pkg : shared widths for the alpha-over segment combiner
// Fixed field widths of the request and result payloads.
// ============================================================================
package aosc_pkg;

    // Pixel index field width (request and result).
    localparam int PIX_W = 10;

    // Colour and transmittance field width (request and result).
    localparam int VAL_W = 16;

endpackage

// ===== design/alpha_over_segment_combine.sv =====
// ============================================================================
// alpha_over_segment_combine : front-to-back "over" compositing per pixel
// Folds depth-ordered segment partials into per-pixel colour and
// transmittance accumulators held in one on-chip memory, and emits the
// merged colour of a pixel on its last segment (black on no-segments).
// ============================================================================
//
//  channel   direction  handshake            payload
//  --------  ---------  -------------------  ----------------------------------
//  request   in         i_valid / o_stall    pixel index, r/g/b partials,
//                                            segment transmittance, first,
//                                            last and no-segments flags
//  result    out        o_valid / i_stall    pixel index, merged r/g/b
//
//  One request per cycle is taken when the result side is not stalled. A
//  result passes the input register, memory read, multiply, add/saturate
//  and write-back stages in turn before it leaves the output register.
//  The rate is set by the single accumulator memory: one read and one write
//  per cycle. Requests to the same pixel may follow back to back; forwarding
//  from the multiply and write-back stages covers the open read-modify-write.
//  A stalled output freezes the whole pipeline, memory port included, and
//  raises o_stall in the same cycle. Reset clears only the valid bits; the
//  accumulator memory is not cleared and a pixel must start with a
//  first-segment request.
//
module alpha_over_segment_combine #(
    parameter int TILE_PIXELS = 1024,
    parameter int FRAC_BITS   = 15
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    // request channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [aosc_pkg::PIX_W-1:0]   i_pixel_index,
    input  logic [aosc_pkg::VAL_W-1:0]   i_red_part,
    input  logic [aosc_pkg::VAL_W-1:0]   i_green_part,
    input  logic [aosc_pkg::VAL_W-1:0]   i_blue_part,
    input  logic [aosc_pkg::VAL_W-1:0]   i_seg_transmit,
    input  logic                         i_first_segment,
    input  logic                         i_last_segment,
    input  logic                         i_no_segments,

    // result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [aosc_pkg::PIX_W-1:0]   o_out_pixel,
    output logic [aosc_pkg::VAL_W-1:0]   o_out_red,
    output logic [aosc_pkg::VAL_W-1:0]   o_out_green,
    output logic [aosc_pkg::VAL_W-1:0]   o_out_blue
);

    import aosc_pkg::*;

    // Accumulator width: values run from 0 to 1.0 inclusive.
    localparam int AW    = FRAC_BITS + 1;
    // Width used to clamp an incoming field against 1.0.
    localparam int PW    = (AW > VAL_W) ? AW : VAL_W;
    localparam int IW    = (TILE_PIXELS > 1) ? $clog2(TILE_PIXELS) : 1;
    localparam int MW    = PIX_W + 12;
    localparam int NCOL  = 3;

    localparam logic [AW-1:0] ONE   = AW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] ONE_P = PW'(1) << FRAC_BITS;

    // ------------------------------------------------------------------
    // Pipeline advance: everything moves unless a result sits unaccepted.
    // ------------------------------------------------------------------
    logic adv;

    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    // ------------------------------------------------------------------
    // Stage A: input register, fields clamped to 1.0 on the way in.
    // ------------------------------------------------------------------
    logic             r_a_valid;
    logic [PIX_W-1:0] r_a_pix;
    logic [AW-1:0]    r_a_part [NCOL];
    logic [AW-1:0]    r_a_tp;
    logic             r_a_first;
    logic             r_a_last;
    logic             r_a_none;

    logic [VAL_W-1:0] in_part [NCOL];
    logic [AW-1:0]    n_a_part [NCOL];
    logic [AW-1:0]    n_a_tp;

    function automatic logic [AW-1:0] clamp_field(input logic [VAL_W-1:0] v);
        logic [PW-1:0] w;
        w = PW'(v);
        if (w > ONE_P) begin
            w = ONE_P;
        end
        return AW'(w);
    endfunction

    assign in_part[0] = i_red_part;
    assign in_part[1] = i_green_part;
    assign in_part[2] = i_blue_part;

    always_comb begin
        for (int k = 0; k < NCOL; k++) begin
            n_a_part[k] = clamp_field(in_part[k]);
        end
        n_a_tp = clamp_field(i_seg_transmit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= i_valid;
        end
        if (adv) begin
            r_a_pix   <= i_pixel_index;
            r_a_part  <= n_a_part;
            r_a_tp    <= n_a_tp;
            r_a_first <= i_first_segment;
            r_a_last  <= i_last_segment;
            r_a_none  <= i_no_segments;
        end
    end

    // Fold the pixel index into the tile: restoring reduction by shifted
    // copies of the tile size; steps that can never fire fall away.
    logic [PIX_W-1:0] a_rem;
    logic [IW-1:0]    a_idx;

    always_comb begin
        logic [MW-1:0] step;
        a_rem = r_a_pix;
        for (int k = PIX_W; k >= 0; k--) begin
            step = MW'(TILE_PIXELS) << k;
            if (MW'(a_rem) >= step) begin
                a_rem = a_rem - PIX_W'(step);
            end
        end
    end

    assign a_idx = IW'(a_rem);

    // ------------------------------------------------------------------
    // Accumulator memory: {transmit, blue, green, red}, one entry per pixel.
    // Read issued from stage A, data registered into stage B.
    // ------------------------------------------------------------------
    logic [4*AW-1:0] mem [TILE_PIXELS];
    logic [4*AW-1:0] r_rdata;

    logic            c_wr;
    logic [4*AW-1:0] c_wdata;

    // ------------------------------------------------------------------
    // Stage B registers
    // ------------------------------------------------------------------
    logic             r_b_valid;
    logic [PIX_W-1:0] r_b_pix;
    logic [IW-1:0]    r_b_idx;
    logic [AW-1:0]    r_b_part [NCOL];
    logic [AW-1:0]    r_b_tp;
    logic             r_b_first;
    logic             r_b_last;
    logic             r_b_none;

    // Stage C registers
    logic             r_c_valid;
    logic [PIX_W-1:0] r_c_pix;
    logic [IW-1:0]    r_c_idx;
    logic [AW-1:0]    r_c_prod [NCOL];
    logic [AW-1:0]    r_c_acc  [NCOL];
    logic [AW-1:0]    r_c_newt;
    logic             r_c_first;
    logic             r_c_last;
    logic             r_c_none;

    // Write-back copy: the entry written at the last advance.
    logic             r_w_valid;
    logic [IW-1:0]    r_w_idx;
    logic [AW-1:0]    r_w_acc [NCOL];
    logic [AW-1:0]    r_w_t;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rdata <= mem[a_idx];
            if (c_wr) begin
                mem[r_c_idx] <= c_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= r_a_valid;
        end
        if (adv) begin
            r_b_pix   <= r_a_pix;
            r_b_idx   <= a_idx;
            r_b_part  <= r_a_part;
            r_b_tp    <= r_a_tp;
            r_b_first <= r_a_first;
            r_b_last  <= r_a_last;
            r_b_none  <= r_a_none;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: pick the current transmittance, multiply.
    // Newest copy wins: item in stage C, then the write-back copy, then
    // the memory word. A first segment restarts from 1.0.
    // ------------------------------------------------------------------
    logic [AW-1:0]   b_t;
    logic [AW-1:0]   b_acc  [NCOL];
    logic [AW-1:0]   b_prod [NCOL];
    logic [AW-1:0]   b_newt;
    logic [2*AW-1:0] b_mul  [NCOL];
    logic [2*AW-1:0] b_mul_t;
    logic            b_hit_c;
    logic            b_hit_w;

    assign b_hit_c = r_c_valid && !r_c_none && (r_c_idx == r_b_idx);
    assign b_hit_w = r_w_valid && (r_w_idx == r_b_idx);

    always_comb begin
        if (r_b_first) begin
            b_t = ONE;
        end else if (b_hit_c) begin
            b_t = r_c_newt;
        end else if (b_hit_w) begin
            b_t = r_w_t;
        end else begin
            b_t = r_rdata[3*AW +: AW];
        end

        for (int k = 0; k < NCOL; k++) begin
            // Colour written at the read edge is not in the memory word yet.
            b_acc[k]  = b_hit_w ? r_w_acc[k] : r_rdata[k*AW +: AW];
            b_mul[k]  = (2*AW)'(b_t) * (2*AW)'(r_b_part[k]);
            b_prod[k] = b_mul[k][FRAC_BITS +: AW];
        end

        b_mul_t = (2*AW)'(b_t) * (2*AW)'(r_b_tp);
        b_newt  = b_mul_t[FRAC_BITS +: AW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (adv) begin
            r_c_valid <= r_b_valid;
        end
        if (adv) begin
            r_c_pix   <= r_b_pix;
            r_c_idx   <= r_b_idx;
            r_c_prod  <= b_prod;
            r_c_acc   <= b_acc;
            r_c_newt  <= b_newt;
            r_c_first <= r_b_first;
            r_c_last  <= r_b_last;
            r_c_none  <= r_b_none;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: add, saturate at 1.0, write back, emit.
    // The previous item in this stage may have touched the same pixel.
    // ------------------------------------------------------------------
    logic [AW-1:0] c_base [NCOL];
    logic [AW:0]   c_sum  [NCOL];
    logic [AW-1:0] c_acc  [NCOL];
    logic          c_hit_w;
    logic          c_emit;

    assign c_hit_w = r_w_valid && (r_w_idx == r_c_idx);

    always_comb begin
        for (int k = 0; k < NCOL; k++) begin
            if (r_c_first) begin
                c_base[k] = '0;
            end else if (c_hit_w) begin
                c_base[k] = r_w_acc[k];
            end else begin
                c_base[k] = r_c_acc[k];
            end
            c_sum[k] = (AW+1)'(c_base[k]) + (AW+1)'(r_c_prod[k]);
            c_acc[k] = (c_sum[k] > (AW+1)'(ONE)) ? ONE : AW'(c_sum[k]);
        end
    end

    assign c_wr    = r_c_valid && !r_c_none;
    assign c_wdata = {r_c_newt, c_acc[2], c_acc[1], c_acc[0]};
    assign c_emit  = r_c_valid && (r_c_none || r_c_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
        end else if (adv) begin
            r_w_valid <= c_wr;
        end
        if (adv) begin
            r_w_idx <= r_c_idx;
            r_w_acc <= c_acc;
            r_w_t   <= r_c_newt;
        end
    end

    // ------------------------------------------------------------------
    // Output register: hold while stalled, black for a pixel without
    // segments.
    // ------------------------------------------------------------------
    logic             r_o_valid;
    logic [PIX_W-1:0] r_o_pix;
    logic [VAL_W-1:0] r_o_red;
    logic [VAL_W-1:0] r_o_green;
    logic [VAL_W-1:0] r_o_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_o_valid <= c_emit;
        end
        if (adv && c_emit) begin
            r_o_pix <= r_c_pix;
            if (r_c_none) begin
                r_o_red   <= '0;
                r_o_green <= '0;
                r_o_blue  <= '0;
            end else begin
                r_o_red   <= VAL_W'(c_acc[0]);
                r_o_green <= VAL_W'(c_acc[1]);
                r_o_blue  <= VAL_W'(c_acc[2]);
            end
        end
    end

    assign o_valid     = r_o_valid;
    assign o_out_pixel = r_o_pix;
    assign o_out_red   = r_o_red;
    assign o_out_green = r_o_green;
    assign o_out_blue  = r_o_blue;

endmodule
